[src/lcar_pkg.sv]
package lcar_pkg;

  localparam int DATA_BITS = 24;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 8;
  localparam int HALF_W    = 16;
  localparam int PULSE_W   = 5;
  localparam int DIVS_W    = CNT_W + 1;

  localparam logic [DATA_BITS-1:0] SIGN_FLIP    = 24'h800000;
  localparam logic [CNT_W-1:0]     TARE_SAMPLES = 8'd20;

  // register indexes of the configuration channel
  localparam logic [1:0] CFG_GAIN_PULSES   = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_AVERAGE_COUNT = 2'd2;
  localparam logic [1:0] CFG_OFFSET        = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic {
    TOP_RUN,
    TOP_DIV
  } top_state_t;

  // serial front end status for the current tick
  typedef struct packed {
    logic                 conv_done;
    logic                 high_nxt;
    logic                 active_nxt;
    logic [DATA_BITS-1:0] word;
  } ser_stat_t;

endpackage

[src/lcar_serial.sv]
module lcar_serial (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      dout,
  input  logic                      pd,
  input  logic [1:0]                gain_pulses,
  input  logic [lcar_pkg::HALF_W-1:0] half_period,
  output lcar_pkg::ser_stat_t       stat
);
  import lcar_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [HALF_W-1:0]    half_r, half_nxt;
  logic [PULSE_W-1:0]   pulse_r, pulse_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [DATA_BITS-1:0] shifted;
  logic [HALF_W-1:0]    hp;
  logic [PULSE_W-1:0]   pulse_inc;
  logic [PULSE_W-1:0]   pulse_end;
  logic                 done;

  assign hp        = (half_period == '0) ? HALF_W'(1) : half_period;
  assign pulse_inc = pulse_r + PULSE_W'(1);
  assign pulse_end = PULSE_W'(DATA_BITS) + PULSE_W'(gain_pulses);
  // one data bit enters as each low phase ends, msb first
  assign shifted   = (pulse_r < PULSE_W'(DATA_BITS)) ? {shift_r[DATA_BITS-2:0], dout}
                                                     : shift_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    pulse_nxt = pulse_r;
    shift_nxt = shift_r;
    done      = 1'b0;
    if (pd) begin
      phase_nxt = PH_IDLE;
      half_nxt  = '0;
      pulse_nxt = '0;
      shift_nxt = '0;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (!dout) begin
            phase_nxt = PH_HIGH;
            half_nxt  = HALF_W'(1);
            pulse_nxt = '0;
            shift_nxt = '0;
          end
        end
        PH_HIGH: begin
          if (half_r >= hp) begin
            phase_nxt = PH_LOW;
            half_nxt  = HALF_W'(1);
          end else begin
            half_nxt = half_r + HALF_W'(1);
          end
        end
        PH_LOW: begin
          if (half_r < hp) begin
            half_nxt = half_r + HALF_W'(1);
          end else if (pulse_inc < pulse_end) begin
            shift_nxt = shifted;
            pulse_nxt = pulse_inc;
            phase_nxt = PH_HIGH;
            half_nxt  = HALF_W'(1);
          end else begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            half_nxt  = '0;
            pulse_nxt = '0;
            shift_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    stat.conv_done  = done;
    stat.high_nxt   = (phase_nxt == PH_HIGH);
    stat.active_nxt = (phase_nxt != PH_IDLE);
    stat.word       = shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      half_r  <= '0;
      pulse_r <= '0;
      shift_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      pulse_r <= pulse_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

[src/lcar_div.sv]
module lcar_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lcar_pkg::SUM_W-1:0]  dividend,
  input  logic [lcar_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [lcar_pkg::SUM_W-1:0]  quotient
);
  import lcar_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/load_cell_adc_reader.sv]
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata: one time tick with the data pin sample
// out_     out  out_tvalid/out_tready  out_tdata: pin level, averaged value and status
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data: register write
//
// a tick that completes no averaging group puts a word into the output register,
// and the next tick can be taken while that word is read out
// a tick that completes a group waits for the bit-serial divider (32 quotient
// bits, then the done register); in_tready is low meanwhile
// in_tready is also low while a finished word sits unread in the output register
// synchronous active-low reset; no clearing pass, held offset resets to zero
module load_cell_adc_reader (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] dout_level, [1] power_down, [2] tare_request

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] sck_level, [1] value_valid, [25:2] net_value,
                                  // [26] tare_done, [27] busy_res

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data    // register value, low bits used
);
  import lcar_pkg::*;

  // configuration registers
  logic [1:0]           gain_pulses_r;
  logic [HALF_W-1:0]    half_period_r;
  logic [CNT_W-1:0]     average_count_r;
  logic [DATA_BITS-1:0] held_offset_r, held_offset_nxt;

  // averaging state
  top_state_t           state_r, state_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 tare_pending_r, tare_pending_nxt;
  logic                 div_tare_r, div_tare_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_sck_r, out_sck_nxt;
  logic                 out_vv_r, out_vv_nxt;
  logic [DATA_BITS-1:0] out_net_r, out_net_nxt;
  logic                 out_tdone_r, out_tdone_nxt;
  logic                 out_busy_r, out_busy_nxt;

  logic                 in_dout, in_pd, in_tare;
  logic                 accept;
  logic                 cfg_write;
  ser_stat_t            ser;

  logic                 tare_new, tp1;
  logic [SUM_W-1:0]     sum1, sum2;
  logic [CNT_W-1:0]     cnt1, cnt2, avg_eff, target;
  logic                 complete;
  logic [DIVS_W-1:0]    divisor;
  logic                 div_start, div_done;
  logic [SUM_W-1:0]     quotient;
  logic [DATA_BITS-1:0] avg;
  logic [DATA_BITS-1:0] net;

  assign in_dout   = in_tdata[0];
  assign in_pd     = in_tdata[1];
  assign in_tare   = in_tdata[2];
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // serial clock generator and bit shifter
  lcar_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .dout        (in_dout),
    .pd          (in_pd),
    .gain_pulses (gain_pulses_r),
    .half_period (half_period_r),
    .stat        (ser)
  );

  // group average, once per group
  lcar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum2),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // a tare request restarts the group before this tick's conversion counts
  assign tare_new = in_tare && !tare_pending_r;
  assign tp1      = tare_pending_r || in_tare;
  assign sum1     = tare_new ? '0 : sum_r;
  assign cnt1     = tare_new ? '0 : cnt_r;
  assign sum2     = sum1 + SUM_W'(ser.word ^ SIGN_FLIP);
  assign cnt2     = cnt1 + CNT_W'(1);
  assign avg_eff  = (average_count_r == '0) ? CNT_W'(1) : average_count_r;
  assign target   = tp1 ? TARE_SAMPLES : avg_eff;
  assign complete = ser.conv_done && ((cnt2 == '0) || (cnt2 >= target));
  // a wrapped count means 256 conversions
  assign divisor  = {cnt2 == '0, cnt2};

  assign avg = quotient[DATA_BITS-1:0];
  assign net = (avg > held_offset_r) ? avg - held_offset_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TOP_RUN: begin
        if (accept && complete) begin
          state_nxt = TOP_DIV;
        end
      end
      TOP_DIV: begin
        if (div_done) begin
          state_nxt = TOP_RUN;
        end
      end
      default: begin
        state_nxt = TOP_RUN;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = (state_r == TOP_RUN) && (!out_valid_r || out_tready);
    div_start = (state_r == TOP_RUN) && accept && complete;
  end

  // group accumulation and output word
  always_comb begin
    sum_nxt          = sum_r;
    cnt_nxt          = cnt_r;
    tare_pending_nxt = tare_pending_r;
    div_tare_nxt     = div_tare_r;
    held_offset_nxt  = held_offset_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_sck_nxt      = out_sck_r;
    out_vv_nxt       = out_vv_r;
    out_net_nxt      = out_net_r;
    out_tdone_nxt    = out_tdone_r;
    out_busy_nxt     = out_busy_r;

    if (accept) begin
      if (complete) begin
        sum_nxt          = '0;
        cnt_nxt          = '0;
        tare_pending_nxt = 1'b0;
        div_tare_nxt     = tp1;
      end else begin
        sum_nxt          = ser.conv_done ? sum2 : sum1;
        cnt_nxt          = ser.conv_done ? cnt2 : cnt1;
        tare_pending_nxt = tp1;
        out_valid_nxt    = 1'b1;
        out_sck_nxt      = in_pd || ser.high_nxt;
        out_vv_nxt       = 1'b0;
        out_net_nxt      = '0;
        out_tdone_nxt    = 1'b0;
        out_busy_nxt     = ser.active_nxt || (cnt_nxt != '0) || tp1;
      end
    end

    // group finished: converter is idle and the group is empty again
    if (div_done) begin
      out_valid_nxt = 1'b1;
      out_sck_nxt   = 1'b0;
      out_busy_nxt  = 1'b0;
      out_vv_nxt    = !div_tare_r;
      out_tdone_nxt = div_tare_r;
      out_net_nxt   = div_tare_r ? '0 : net;
      if (div_tare_r) begin
        held_offset_nxt = avg;
      end
    end

    if (cfg_write && (cfg_index == CFG_OFFSET)) begin
      held_offset_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_pulses_r   <= 2'd1;
      half_period_r   <= HALF_W'(20);
      average_count_r <= CNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_PULSES:   gain_pulses_r   <= cfg_data[1:0];
        CFG_HALF_PERIOD:   half_period_r   <= cfg_data[HALF_W-1:0];
        CFG_AVERAGE_COUNT: average_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= TOP_RUN;
      sum_r          <= '0;
      cnt_r          <= '0;
      tare_pending_r <= 1'b0;
      div_tare_r     <= 1'b0;
      held_offset_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sum_r          <= sum_nxt;
      cnt_r          <= cnt_nxt;
      tare_pending_r <= tare_pending_nxt;
      div_tare_r     <= div_tare_nxt;
      held_offset_r  <= held_offset_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sck_r   <= out_sck_nxt;
    out_vv_r    <= out_vv_nxt;
    out_net_r   <= out_net_nxt;
    out_tdone_r <= out_tdone_nxt;
    out_busy_r  <= out_busy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_busy_r, out_tdone_r, out_net_r, out_vv_r, out_sck_r};

  // the divider never finishes into an occupied output register
  a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !out_valid_r)
    else $error("divider result while output word pending");

  // a word never reports a value and a tare at once
  a_vv_tdone_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_vv_r && out_tdone_r))
    else $error("value and tare flagged together");

  // net value is zero unless a value is reported
  a_net_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vv_r) |-> (out_net_r == '0))
    else $error("net value without value_valid");

  // a finished tare leaves no pending request behind
  a_tare_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && div_tare_r) |=> !tare_pending_r)
    else $error("tare still pending after offset update");

endmodule
